@@ src/jtli_pkg.sv @@
// ----------------------------------------------------------------------------
// jtli_pkg
// Shared types and constants for the joint trajectory linear interpolator.
// ----------------------------------------------------------------------------
package jtli_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int MAX_JOINTS    = 6;
  localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
  localparam int JT_W          = $clog2(MAX_JOINTS);
  localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
  localparam int POS_AW        = WP_AW + JT_W;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_DONE    = 3'd0;
  localparam status_t ST_INTERP  = 3'd1;
  localparam status_t ST_FIRST   = 3'd2;
  localparam status_t ST_LAST    = 3'd3;
  localparam status_t ST_INVALID = 3'd4;
  localparam status_t ST_NEGTIME = 3'd5;
  localparam status_t ST_FULL    = 3'd6;
  localparam status_t ST_ORDER   = 3'd7;

  typedef struct packed {
    logic              t_we;
    logic [WP_AW-1:0]  t_waddr;
    logic [31:0]       t_wdata;
    logic [WP_AW-1:0]  t_raddr;
    logic              p_we;
    logic [POS_AW-1:0] p_waddr;
    logic [31:0]       p_wdata;
    logic [POS_AW-1:0] p_raddr;
  } store_req_t;

  typedef struct packed {
    logic        start;
    logic [32:0] mag;
    logic [31:0] span;
    logic [31:0] den;
  } md_req_t;

endpackage

@@ src/jtli_store.sv @@
// ----------------------------------------------------------------------------
// jtli_store
// Waypoint time and position memories with registered reads.
// ----------------------------------------------------------------------------
module jtli_store (
  input  logic                clk,
  input  jtli_pkg::store_req_t req,
  output logic [31:0]         t_rdata,
  output logic [31:0]         p_rdata
);
  import jtli_pkg::*;

  logic [31:0] time_mem [MAX_WAYPOINTS];
  logic [31:0] pos_mem  [2**POS_AW];

  always_ff @(posedge clk) begin
    if (req.t_we) begin
      time_mem[req.t_waddr] <= req.t_wdata;
    end
    t_rdata <= time_mem[req.t_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.p_we) begin
      pos_mem[req.p_waddr] <= req.p_wdata;
    end
    p_rdata <= pos_mem[req.p_raddr];
  end

endmodule

@@ src/jtli_muldiv.sv @@
// ----------------------------------------------------------------------------
// jtli_muldiv
// Multiplies two magnitudes, then divides by a restoring loop, one bit a cycle.
// ----------------------------------------------------------------------------
module jtli_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  jtli_pkg::md_req_t req,
  output logic              done,
  output logic [32:0]       quo
);
  import jtli_pkg::*;

  logic        busy;
  logic        mul_phase;
  logic [5:0]  cnt;
  logic [32:0] mag;
  logic [31:0] span;
  logic [31:0] den;
  logic [31:0] rem;
  logic [63:0] dvd;
  logic [64:0] prod;
  logic [32:0] rem_sh;
  logic        ge;

  assign prod   = mag * span;
  assign rem_sh = {rem, dvd[63]};
  assign ge     = rem_sh >= {1'b0, den};
  assign quo    = dvd[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mul_phase <= 1'b0;
      done      <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy      <= 1'b1;
        mul_phase <= 1'b1;
        mag       <= req.mag;
        span      <= req.span;
        den       <= req.den;
      end else if (busy && mul_phase) begin
        mul_phase <= 1'b0;
        dvd       <= prod[63:0];
        rem       <= '0;
        cnt       <= '0;
      end else if (busy) begin
        rem <= ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
        dvd <= {dvd[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/joint_trajectory_linear_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// joint_trajectory_linear_interpolator_top
// Waypoint table with clear, append and query, and linear interpolation.
// ----------------------------------------------------------------------------
// A clear, an unused or a rejected command goes straight to the result beat. An append
// writes the time and every joint position. A query at an end reads each joint's position;
// an interpolating query searches the segments one by one, then for each joint reads two
// positions and uses the shared multiply and bit-serial divide unit.
// One item at a time: the next beat is taken in the cycle after the result beat leaves.
// Synchronous reset empties the table, clears the invalid flag and sets joint_count to 6.
module joint_trajectory_linear_interpolator_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  logic signed [31:0]     time_us,
  input  logic signed [31:0]     joint_in_0,
  input  logic signed [31:0]     joint_in_1,
  input  logic signed [31:0]     joint_in_2,
  input  logic signed [31:0]     joint_in_3,
  input  logic signed [31:0]     joint_in_4,
  input  logic signed [31:0]     joint_in_5,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             status,
  output logic signed [31:0]     joint_out_0,
  output logic signed [31:0]     joint_out_1,
  output logic signed [31:0]     joint_out_2,
  output logic signed [31:0]     joint_out_3,
  output logic signed [31:0]     joint_out_4,
  output logic signed [31:0]     joint_out_5
);
  import jtli_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_WRITE   = 11'b000_0000_0010,
    S_PT_RD   = 11'b000_0000_0100,
    S_PT_CAP  = 11'b000_0000_1000,
    S_SR_RD   = 11'b000_0001_0000,
    S_SR_CHK  = 11'b000_0010_0000,
    S_IN_RD0  = 11'b000_0100_0000,
    S_IN_RD1  = 11'b000_1000_0000,
    S_IN_GO   = 11'b001_0000_0000,
    S_IN_WAIT = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

  state_t              state;
  logic [2:0]          joint_count;
  logic [CNT_W-1:0]    wp_count;
  logic                table_invalid;
  logic signed [31:0]  first_time;
  logic signed [31:0]  last_time;
  logic signed [31:0]  t_q;
  logic signed [31:0]  jin [MAX_JOINTS];
  logic signed [31:0]  res [MAX_JOINTS];
  status_t             status_q;
  logic [JT_W-1:0]     jidx;
  logic [WP_AW-1:0]    widx;
  logic signed [31:0]  t0;
  logic signed [31:0]  t1;
  logic signed [31:0]  p0;
  logic                neg;
  logic [JT_W-1:0]     top_joint;
  store_req_t          st_req;
  logic [31:0]         t_rdata;
  logic [31:0]         p_rdata;
  md_req_t             md_req;
  logic                md_done;
  logic [32:0]         md_quo;
  logic signed [32:0]  dp;
  logic signed [33:0]  qs;
  logic signed [33:0]  sum;
  logic signed [31:0]  sat;
  logic                accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    if (joint_count == 3'd0) begin
      top_joint = '0;
    end else if (joint_count > 3'(MAX_JOINTS)) begin
      top_joint = JT_W'(MAX_JOINTS - 1);
    end else begin
      top_joint = JT_W'(joint_count - 3'd1);
    end
  end

  always_comb begin
    st_req         = '0;
    st_req.t_waddr = wp_count[WP_AW-1:0];
    st_req.t_wdata = t_q;
    st_req.p_waddr = {wp_count[WP_AW-1:0], jidx};
    st_req.p_wdata = jin[jidx];
    st_req.t_raddr = WP_AW'(widx + 1'b1);
    st_req.p_raddr = {widx, jidx};
    if (state == S_WRITE) begin
      st_req.p_we = 1'b1;
      st_req.t_we = jidx == '0;
    end
    if (state == S_IN_RD1) begin
      st_req.p_raddr = {WP_AW'(widx + 1'b1), jidx};
    end
  end

  jtli_store u_store (
    .clk     (clk),
    .req     (st_req),
    .t_rdata (t_rdata),
    .p_rdata (p_rdata)
  );

  assign dp = {p_rdata[31], p_rdata} - {p0[31], p0};

  always_comb begin
    md_req       = '0;
    md_req.start = state == S_IN_GO;
    md_req.mag   = dp[32] ? 33'(-dp) : dp;
    md_req.span  = 32'(t_q - t0);
    md_req.den   = 32'(t1 - t0);
  end

  jtli_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .done (md_done),
    .quo  (md_quo)
  );

  assign qs  = neg ? -{1'b0, md_quo} : {1'b0, md_quo};
  assign sum = {{2{p0[31]}}, p0} + qs;

  always_comb begin
    if (sum > 34'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -34'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= 3'd6;
    end else if (cfg_wr_en) begin
      joint_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wp_count      <= '0;
      table_invalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            t_q    <= time_us;
            jin[0] <= joint_in_0;
            jin[1] <= joint_in_1;
            jin[2] <= joint_in_2;
            jin[3] <= joint_in_3;
            jin[4] <= joint_in_4;
            jin[5] <= joint_in_5;
            for (int k = 0; k < MAX_JOINTS; k++) begin
              res[k] <= '0;
            end
            jidx     <= '0;
            widx     <= '0;
            status_q <= ST_DONE;
            state    <= S_OUT;
            case (command)
              CMD_CLEAR: begin
                wp_count      <= '0;
                table_invalid <= 1'b0;
              end
              CMD_APPEND: begin
                if (time_us < 0) begin
                  table_invalid <= 1'b1;
                  status_q      <= ST_NEGTIME;
                end else if (wp_count >= CNT_W'(MAX_WAYPOINTS)) begin
                  status_q <= ST_FULL;
                end else if (wp_count != '0 && time_us < last_time) begin
                  status_q <= ST_ORDER;
                end else begin
                  state <= S_WRITE;
                end
              end
              CMD_QUERY: begin
                if (wp_count == '0 || table_invalid) begin
                  status_q <= ST_INVALID;
                end else if (time_us < 0) begin
                  status_q <= ST_NEGTIME;
                end else if (time_us <= first_time) begin
                  status_q <= ST_FIRST;
                  state    <= S_PT_RD;
                end else if (time_us >= last_time) begin
                  status_q <= ST_LAST;
                  widx     <= WP_AW'(wp_count - 1'b1);
                  state    <= S_PT_RD;
                end else begin
                  status_q <= ST_INTERP;
                  t0       <= first_time;
                  state    <= S_SR_RD;
                end
              end
              default: begin
                status_q <= ST_DONE;
              end
            endcase
          end
        end
        S_WRITE: begin
          if (jidx == JT_W'(MAX_JOINTS - 1)) begin
            if (wp_count == '0) begin
              first_time <= t_q;
            end
            last_time <= t_q;
            wp_count  <= wp_count + 1'b1;
            state     <= S_OUT;
          end else begin
            jidx <= jidx + 1'b1;
          end
        end
        S_PT_RD: begin
          state <= S_PT_CAP;
        end
        S_PT_CAP: begin
          res[jidx] <= p_rdata;
          if (jidx == top_joint) begin
            state <= S_OUT;
          end else begin
            jidx  <= jidx + 1'b1;
            state <= S_PT_RD;
          end
        end
        S_SR_RD: begin
          state <= S_SR_CHK;
        end
        S_SR_CHK: begin
          if (t_q <= $signed(t_rdata)) begin
            t1    <= t_rdata;
            state <= S_IN_RD0;
          end else begin
            t0    <= t_rdata;
            widx  <= widx + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_IN_RD0: begin
          state <= S_IN_RD1;
        end
        S_IN_RD1: begin
          p0    <= p_rdata;
          state <= S_IN_GO;
        end
        S_IN_GO: begin
          neg   <= dp[32];
          state <= S_IN_WAIT;
        end
        S_IN_WAIT: begin
          if (md_done) begin
            res[jidx] <= sat;
            if (jidx == top_joint) begin
              state <= S_OUT;
            end else begin
              jidx  <= jidx + 1'b1;
              state <= S_IN_RD0;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status      = status_q;
  assign joint_out_0 = res[0];
  assign joint_out_1 = res[1];
  assign joint_out_2 = res[2];
  assign joint_out_3 = res[3];
  assign joint_out_4 = res[4];
  assign joint_out_5 = res[5];

endmodule
